>>> rtl/sprite_cell_bitmap_unpacker_macros.svh
// Assertion macros for the sprite cell bitmap unpacker.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SPRITE_CELL_BITMAP_UNPACKER_MACROS_SVH
`define SPRITE_CELL_BITMAP_UNPACKER_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define SCBU_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scbu: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define SCBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scbu: next-cycle check failed");

`endif

>>> rtl/scbu_pkg.sv
// Shared types and codes for the sprite cell bitmap unpacker.
// No dependencies; imported by scbu_parser and the top level.
package scbu_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 256;
  localparam int DEFAULT_MAX_HEIGHT = 256;

  // Result kinds
  localparam logic [2:0] K_HEADER    = 3'd0;
  localparam logic [2:0] K_HDR_DONE  = 3'd1;
  localparam logic [2:0] K_BITMAP    = 3'd2;
  localparam logic [2:0] K_ATTR      = 3'd3;
  localparam logic [2:0] K_BAD_MAGIC = 3'd4;
  localparam logic [2:0] K_TOO_LARGE = 3'd5;
  localparam logic [2:0] K_TRAILING  = 3'd6;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_index;
    logic [7:0]  pixel_column;
    logic [7:0]  pixel_row;
    logic        image_done;
  } out_t;

  // Result of one parse step: whether the byte yields a transaction, and its payload
  typedef struct packed {
    logic valid;
    out_t item;
  } step_res_t;

endpackage

>>> rtl/scbu_parser.sv
// Parse state and per-byte result logic for the sprite cell bitmap unpacker.
// Depends on scbu_pkg and sprite_cell_bitmap_unpacker_macros.svh.
module scbu_parser import scbu_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_t       in_item,
  output step_res_t res
);

  localparam int CCW = $clog2(MAX_WIDTH / 8 + 1);
  localparam int RCW = $clog2(MAX_HEIGHT / 8 + 1);

  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_CELLS  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [3:0] HDR_LAST = 4'd13;

  logic [1:0]     phase_r,  phase_nxt;
  logic [3:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]     low_r,    low_nxt;
  logic [16:0]    frames_r, frames_nxt;
  logic [15:0]    width_r,  width_nxt;
  logic [15:0]    height_r, height_nxt;
  logic [15:0]    frame_r,  frame_nxt;
  logic [RCW-1:0] row_r,    row_nxt;
  logic [CCW-1:0] col_r,    col_nxt;
  logic [3:0]     line_r,   line_nxt;

  logic [1:0]     eff_phase;
  logic [3:0]     idx;
  logic [7:0]     b;
  logic [7:0]     magic;
  logic [15:0]    word_new;
  logic [15:0]    col_inc, row_inc;
  logic [16:0]    frame_inc;
  logic [CCW+2:0] col_pix;
  logic [RCW+2:0] row_pix;
  logic [15:0]    row_line;
  logic           last_frame;

  assign b         = in_item.file_byte;
  assign eff_phase = in_item.start_of_file ? PH_HEADER : phase_r;
  assign idx       = in_item.start_of_file ? 4'd0 : hdr_cnt_r;
  assign word_new  = {b, low_r};

  // Expected magic byte for the first four header positions
  always_comb begin
    case (idx[1:0])
      2'd0:    magic = 8'h53;
      2'd1:    magic = 8'h65;
      2'd2:    magic = 8'h76;
      default: magic = 8'h00;
    endcase
  end

  // Cell walk arithmetic
  assign col_inc    = 16'(col_r) + 16'd1;
  assign row_inc    = 16'(row_r) + 16'd1;
  assign frame_inc  = {1'b0, frame_r} + 17'd1;
  assign last_frame = frame_inc >= frames_r;
  assign col_pix    = {col_r, 3'b000};
  assign row_pix    = {row_r, 3'b000};
  assign row_line   = 16'(row_pix) | {12'd0, line_r};

  // Next state and result for the byte on the input
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    low_nxt     = in_item.start_of_file ? 8'd0 : low_r;
    frames_nxt  = frames_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    frame_nxt   = frame_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    line_nxt    = line_r;
    res         = '0;
    res.item.data_byte = b;

    case (eff_phase)
      PH_HEADER: begin
        res.valid = 1'b1;
        phase_nxt = PH_HEADER;
        if (idx < 4'd4 && b != magic) begin
          res.item.kind = K_BAD_MAGIC;
          phase_nxt     = PH_WAIT;
          hdr_cnt_nxt   = idx;
        end else begin
          if (idx inside {4'd8, 4'd10, 4'd12}) begin
            low_nxt = b;
          end else if (idx == 4'd9) begin
            frames_nxt = {1'b0, word_new} + 17'd1;
          end else if (idx == 4'd11) begin
            width_nxt = word_new;
          end else if (idx == HDR_LAST) begin
            height_nxt = word_new;
          end

          if (idx < HDR_LAST) begin
            hdr_cnt_nxt   = idx + 4'd1;
            res.item.kind = K_HEADER;
          end else if (width_r > 16'(MAX_WIDTH) || word_new > 16'(MAX_HEIGHT)) begin
            hdr_cnt_nxt   = idx;
            res.item.kind = K_TOO_LARGE;
            phase_nxt     = PH_WAIT;
          end else begin
            hdr_cnt_nxt   = idx;
            res.item.kind = K_HDR_DONE;
            frame_nxt     = '0;
            row_nxt       = '0;
            col_nxt       = '0;
            line_nxt      = '0;
            // No whole cell in either direction: nothing follows the header
            if (width_r[15:3] == 13'd0 || word_new[15:3] == 13'd0) begin
              phase_nxt           = PH_DONE;
              res.item.image_done = 1'b1;
            end else begin
              phase_nxt = PH_CELLS;
            end
          end
        end
      end

      PH_CELLS: begin
        res.valid = 1'b1;
        res.item.pixel_column = 8'(col_pix);
        if (line_r < 4'd8) begin
          res.item.kind        = K_BITMAP;
          res.item.frame_index = frame_r;
          res.item.pixel_row   = row_line[7:0];
          line_nxt             = line_r + 4'd1;
        end else begin
          // Attribute byte closes the cell; advance column, row, frame
          res.item.kind      = K_ATTR;
          res.item.pixel_row = 8'(row_pix);
          line_nxt           = '0;
          col_nxt            = col_inc[CCW-1:0];
          if (col_inc >= {3'b000, width_r[15:3]}) begin
            col_nxt = '0;
            row_nxt = row_inc[RCW-1:0];
            if (row_inc >= {3'b000, height_r[15:3]}) begin
              row_nxt = '0;
              if (last_frame) begin
                res.item.image_done = 1'b1;
                phase_nxt           = PH_DONE;
              end else begin
                frame_nxt = frame_inc[15:0];
              end
            end
          end
          res.item.frame_index = frame_nxt;
        end
      end

      PH_DONE: begin
        res.valid     = 1'b1;
        res.item.kind = K_TRAILING;
      end

      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  // State registers, updated only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      hdr_cnt_r <= '0;
      low_r     <= '0;
      frames_r  <= '0;
      width_r   <= '0;
      height_r  <= '0;
      frame_r   <= '0;
      row_r     <= '0;
      col_r     <= '0;
      line_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      low_r     <= low_nxt;
      frames_r  <= frames_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      frame_r   <= frame_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      line_r    <= line_nxt;
    end
  end

  // Checks on the cell walk
  logic in_cells;
  logic col_in_range;
  logic frame_in_range;
  logic bitmap_step;

  assign in_cells       = phase_r == PH_CELLS;
  assign col_in_range   = 16'(col_r) < {3'b000, width_r[15:3]};
  assign frame_in_range = {1'b0, frame_r} < frames_r;
  assign bitmap_step    = step && res.valid && res.item.kind == K_BITMAP;

`include "sprite_cell_bitmap_unpacker_macros.svh"

  `SCBU_ASSERT_IMPLIES(a_line_range, in_cells, line_r <= 4'd8)
  `SCBU_ASSERT_IMPLIES(a_col_range, in_cells, col_in_range)
  `SCBU_ASSERT_IMPLIES(a_frame_range, in_cells, frame_in_range)
  `SCBU_ASSERT_NEXT(a_line_advance, bitmap_step, line_r != 4'd0)

endmodule

>>> rtl/sprite_cell_bitmap_unpacker.sv
// Top level of the sprite cell bitmap unpacker: handshake and result register.
// Depends on scbu_pkg and scbu_parser.

// One file byte is taken per clock while in_ready is high, and its result, if
// any, appears in the output register on the next cycle, so the sustained
// rate is one byte per clock while out_ready stays high. The only stored
// element between input and output is the output register; the parser's
// counters advance in the same cycle a byte is taken. in_ready stays high
// while the output register is empty or being drained, so a stalled consumer
// holds back at most one result. Bytes that arrive before a start-of-file flag
// (after reset, bad magic or an oversize header) are consumed without a result.
module sprite_cell_bitmap_unpacker import scbu_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic      out_valid_r;
  out_t      out_data_r;
  logic      in_fire;
  step_res_t res;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  scbu_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .in_item (in_data),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
